/* hw/rtl/bpd_pkg.sv */
// Shared types and codes for the button press duration power control block.
// Used by the channel interfaces, the decision core and the top level.
`timescale 1ns / 1ps
`default_nettype none
package bpd_pkg;

  localparam int BTN_COUNT = 3;
  localparam logic [7:0] CNT_MAX = 8'hFF;

  localparam logic [7:0] SHORT_RESET   = 8'd1;
  localparam logic [7:0] LONG_RESET    = 8'd4;
  localparam logic [7:0] STUCK_RESET   = 8'd10;
  localparam logic [7:0] RESTORE_RESET = 8'd5;

  localparam logic       CMD_TICK    = 1'b0;
  localparam logic       LVL_PRESSED = 1'b0;
  localparam logic [1:0] BTN_RESET   = 2'd0;
  localparam logic [1:0] BTN_POWER   = 2'd1;
  localparam logic [1:0] BTN_CONSOLE = 2'd2;
  localparam logic [1:0] PWR_OFF     = 2'd0;
  localparam logic [1:0] PWR_ON      = 2'd1;

  typedef enum logic [1:0] {
    CFG_SHORT   = 2'd0,
    CFG_LONG    = 2'd1,
    CFG_STUCK   = 2'd2,
    CFG_RESTORE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_BMC_REBOOT = 4'd1,
    ACT_HOST_RESET = 4'd2,
    ACT_POWER_ON   = 4'd3,
    ACT_POWER_OFF  = 4'd4,
    ACT_GRACEFUL   = 4'd5,
    ACT_REFUSED    = 4'd6,
    ACT_CONSOLE    = 4'd7,
    ACT_RESTORE    = 4'd8
  } act_t;

  typedef struct packed {
    logic [7:0] short_s;
    logic [7:0] long_s;
    logic [7:0] stuck_s;
    logic [7:0] restore_s;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [1:0] button;
    logic       level;
    logic       console_to_host;
    logic [1:0] host_power;
    logic [7:0] post_code;
  } item_t;

  typedef struct packed {
    act_t       action;
    logic [7:0] display_value;
    logic [7:0] hold_seconds;
    logic [2:0] stuck_asserted;
    logic       stuck_cleared;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/bpd_if.sv */
// Valid/ready channel interfaces for input words, result words and config writes.
// Depends on bpd_pkg for the codes and widths.
`timescale 1ns / 1ps
`default_nettype none
interface bpd_in_if;
  import bpd_pkg::*;
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] button;
  logic       level;
  logic       console_to_host;
  logic [1:0] host_power;
  logic [7:0] post_code;
  modport source (output valid, command, button, level, console_to_host, host_power,
                  post_code, input ready);
  modport sink (input valid, command, button, level, console_to_host, host_power,
                post_code, output ready);
endinterface

interface bpd_out_if;
  import bpd_pkg::*;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] display_value;
  logic [7:0] hold_seconds;
  logic [2:0] stuck_asserted;
  logic       stuck_cleared;
  modport source (output valid, action, display_value, hold_seconds, stuck_asserted,
                  stuck_cleared, input ready);
  modport sink (input valid, action, display_value, hold_seconds, stuck_asserted,
                stuck_cleared, output ready);
endinterface

interface bpd_cfg_if;
  import bpd_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpd_core.sv */
// Button state, hold counters and restore timer, with the per-word action decision.
// Depends on bpd_pkg; the top level supplies the accept strobe and config.
`timescale 1ns / 1ps
`default_nettype none
module bpd_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire bpd_pkg::item_t item,
  input  wire bpd_pkg::cfg_t  cfg,
  output bpd_pkg::res_t       res
);
  import bpd_pkg::*;

  logic [BTN_COUNT-1:0] held_r, held_nxt;
  logic [7:0]           cnt_r [BTN_COUNT];
  logic [7:0]           cnt_nxt [BTN_COUNT];
  logic                 pend_r, pend_nxt;
  logic [7:0]           saved_r, saved_nxt;
  logic [7:0]           timer_r, timer_nxt;
  logic [7:0]           timer_inc;
  logic [7:0]           h;
  logic                 in_window;

  always_comb begin
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    saved_nxt = saved_r;
    timer_nxt = timer_r;
    res       = '0;
    res.action = ACT_NONE;
    h         = cnt_r[item.button];
    in_window = (h >= cfg.short_s) && (h < cfg.stuck_s);
    timer_inc = (timer_r < CNT_MAX) ? timer_r + 8'd1 : timer_r;
    if (item.command == CMD_TICK) begin
      for (int i = 0; i < BTN_COUNT; i++) begin
        if (held_r[i] && cnt_r[i] < CNT_MAX) begin
          cnt_nxt[i] = cnt_r[i] + 8'd1;
          res.stuck_asserted[i] = (cnt_nxt[i] == cfg.stuck_s);
        end
      end
      if (pend_r) begin
        timer_nxt = timer_inc;
        if (timer_inc >= cfg.restore_s) begin
          res.action        = ACT_RESTORE;
          res.display_value = saved_r;
          pend_nxt          = 1'b0;
          timer_nxt         = '0;
        end
      end
    end else if (item.button != 2'd3 &&
                 !(item.button == BTN_POWER && !item.console_to_host)) begin
      if (item.level == LVL_PRESSED) begin
        held_nxt[item.button] = 1'b1;
        cnt_nxt[item.button]  = '0;
      end else if (held_r[item.button]) begin
        held_nxt[item.button] = 1'b0;
        res.hold_seconds      = h;
        if (item.button == BTN_CONSOLE) begin
          if (h < cfg.stuck_s) begin
            res.action        = ACT_CONSOLE;
            res.display_value = {7'd0, item.console_to_host};
            if (!pend_r) begin
              pend_nxt  = 1'b1;
              saved_nxt = item.post_code;
            end
            timer_nxt = '0;
          end else if (h > cfg.stuck_s) begin
            res.stuck_cleared = 1'b1;
          end
        end else if (in_window) begin
          if (item.button == BTN_RESET) begin
            if (!item.console_to_host) begin
              res.action = ACT_BMC_REBOOT;
            end else begin
              res.action = (item.host_power == PWR_ON) ? ACT_HOST_RESET : ACT_REFUSED;
            end
          end else begin
            if (item.host_power == PWR_OFF) begin
              res.action = ACT_POWER_ON;
            end else if (item.host_power == PWR_ON) begin
              res.action = (h > cfg.long_s) ? ACT_POWER_OFF : ACT_GRACEFUL;
            end else begin
              res.action = ACT_REFUSED;
            end
          end
        end else if (h > cfg.stuck_s) begin
          res.stuck_cleared = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      pend_r  <= 1'b0;
      saved_r <= '0;
      timer_r <= '0;
      for (int i = 0; i < BTN_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (step) begin
      held_r  <= held_nxt;
      pend_r  <= pend_nxt;
      saved_r <= saved_nxt;
      timer_r <= timer_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/button_press_duration_power_control.sv */
// Top level: config registers, decision core and a two-entry result buffer.
// Depends on bpd_pkg, the channel interfaces in bpd_if and bpd_core.
//
//   channel  | direction | payload
//   in_ch    | sink      | command, button, level, console_to_host, host_power, post code
//   out_ch   | source    | action, display_value, hold_seconds, stuck marks
//   cfg_ch   | sink      | index, data (always ready)
//
// Each result goes to the output register, or to the skid entry when one already waits.
// A new word is taken every cycle while in_ready is high; the output register plus one
// skid entry keep input accepted while a result waits. in_ready drops only when both
// are full. Reset is synchronous and restores the config defaults and released buttons.
`timescale 1ns / 1ps
`default_nettype none
module button_press_duration_power_control (
  input wire logic clk,
  input wire logic rst_n,
  bpd_in_if.sink   in_ch,
  bpd_out_if.source out_ch,
  bpd_cfg_if.sink  cfg_ch
);
  import bpd_pkg::*;

  cfg_t  cfg_r;
  item_t item;
  res_t  res;
  res_t  out_r, skid_r;
  logic  out_valid_r, skid_valid_r;
  logic  accept, take;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !skid_valid_r;
  assign accept       = in_ch.valid && in_ch.ready;
  assign take         = out_valid_r && out_ch.ready;

  assign item = '{command: in_ch.command, button: in_ch.button, level: in_ch.level,
                  console_to_host: in_ch.console_to_host, host_power: in_ch.host_power,
                  post_code: in_ch.post_code};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{short_s: SHORT_RESET, long_s: LONG_RESET, stuck_s: STUCK_RESET,
                 restore_s: RESTORE_RESET};
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_SHORT:   cfg_r.short_s   <= cfg_ch.data;
        CFG_LONG:    cfg_r.long_s    <= cfg_ch.data;
        CFG_STUCK:   cfg_r.stuck_s   <= cfg_ch.data;
        CFG_RESTORE: cfg_r.restore_s <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  bpd_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (accept),
    .item (item),
    .cfg  (cfg_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        out_r <= res;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.action         = out_r.action;
  assign out_ch.display_value  = out_r.display_value;
  assign out_ch.hold_seconds   = out_r.hold_seconds;
  assign out_ch.stuck_asserted = out_r.stuck_asserted;
  assign out_ch.stuck_cleared  = out_r.stuck_cleared;

endmodule
`default_nettype wire

/* hw/rtl/bpd_checker.sv */
// Port-level checks for the button press duration power control block.
// Depends on bpd_pkg; bound to the top level by the statement at the end.
`timescale 1ns / 1ps
`default_nettype none
module bpd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] action,
  input wire logic [7:0] display_value,
  input wire logic [7:0] hold_seconds,
  input wire logic [2:0] stuck_asserted,
  input wire logic       stuck_cleared
);
  import bpd_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(display_value))
    else $error("Stalled result word changed.");

  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("Input stalled while no result is waiting.");

  a_stuck_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stuck_asserted != 3'd0 |->
      (action == ACT_NONE || action == ACT_RESTORE) && hold_seconds == 8'd0 && !stuck_cleared)
    else $error("Stuck mark mixed with edge results.");

  a_display_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && action != ACT_CONSOLE && action != ACT_RESTORE |-> display_value == 8'd0)
    else $error("Display value without a display action.");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> action <= ACT_RESTORE && (action != ACT_CONSOLE || display_value <= 8'd1))
    else $error("Result action out of range.");

endmodule

bind button_press_duration_power_control bpd_checker u_bpd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .action        (out_ch.action),
  .display_value (out_ch.display_value),
  .hold_seconds  (out_ch.hold_seconds),
  .stuck_asserted(out_ch.stuck_asserted),
  .stuck_cleared (out_ch.stuck_cleared)
);
`default_nettype wire
